@@ rtl/core/bc_pkg.sv @@
// Shared types and constants for the binomial coefficient block.
// Used by bc_alu and binomial_coefficient_top; no dependencies.
package bc_pkg;

  localparam int DATA_W        = 32;  // width of the stream fields
  localparam int WORD_BITS_DEF = 32;  // default arithmetic word width

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MINK,
    S_LOOP,
    S_WAIT_N,
    S_DIV_R_GO,
    S_WAIT_R,
    S_MUL_GO,
    S_WAIT_M,
    S_DIV_P_GO,
    S_WAIT_P,
    S_STEP_END,
    S_FIN
  } state_t;

endpackage

@@ rtl/core/bc_alu.sv @@
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle.
// A single adder/subtractor serves both operations. Depends on bc_pkg.
module bc_alu #(
  parameter int WORD_BITS = bc_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bc_pkg::alu_ctrl_t     ctrl,
  input  logic [WORD_BITS-1:0]  opa,   // dividend or multiplier
  input  logic [WORD_BITS-1:0]  opb,   // divisor or multiplicand
  output bc_pkg::alu_stat_t     stat,
  output logic [WORD_BITS-1:0]  hi,    // remainder or product high half
  output logic [WORD_BITS-1:0]  lo     // quotient or product low half
);
  import bc_pkg::*;

  localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  alu_op_t              op_r, op_nxt;
  logic [WORD_BITS-1:0] hi_r, hi_nxt;
  logic [WORD_BITS-1:0] lo_r, lo_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;

  logic [WORD_BITS:0]   sh;
  logic [WORD_BITS+1:0] add_x, add_y, sum;
  logic                 cin;

  always_comb begin
    sh    = {hi_r, lo_r[WORD_BITS-1]};
    cin   = (op_r == ALU_DIV);
    add_x = (op_r == ALU_DIV) ? {1'b0, sh} : {2'b00, hi_r};
    if (op_r == ALU_DIV) begin
      add_y = ~{2'b00, b_r};
    end else begin
      add_y = lo_r[0] ? {2'b00, b_r} : '0;
    end
    sum = add_x + add_y + (WORD_BITS+2)'(cin);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    b_nxt    = b_r;
    if (busy_r) begin
      unique case (op_r)
        ALU_DIV: begin
          // keep the trial difference when it does not borrow
          if (!sum[WORD_BITS+1]) begin
            hi_nxt = sum[WORD_BITS-1:0];
            lo_nxt = {lo_r[WORD_BITS-2:0], 1'b1};
          end else begin
            hi_nxt = sh[WORD_BITS-1:0];
            lo_nxt = {lo_r[WORD_BITS-2:0], 1'b0};
          end
        end
        ALU_MUL: begin
          hi_nxt = sum[WORD_BITS:1];
          lo_nxt = {sum[0], lo_r[WORD_BITS-1:1]};
        end
        default: begin
          hi_nxt = hi_r;
        end
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = ctrl.op;
      hi_nxt   = '0;
      lo_nxt   = opa;
      b_nxt    = opb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ALU_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    b_r  <= b_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign hi        = hi_r;
  assign lo        = lo_r;

endmodule

@@ rtl/core/binomial_coefficient_top.sv @@
// Binomial coefficient C(n,k), multiplicative scheme, on one shared serial unit.
// Each loop step d runs one to three divides and one multiply, then the step-end state.
// An item passes the setup states, then runs min(k,n-k) steps or until overflow
// (at most 18 steps for 32-bit words); one item at a time.
// Synchronous active-low reset clears the sequencer and the output valid.
module binomial_coefficient_top #(
  parameter int WORD_BITS = bc_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [2*bc_pkg::DATA_W-1:0] in_tdata,  // n_total [31:0], k_chosen [63:32]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [bc_pkg::DATA_W-1:0] out_tdata,   // coefficient [31:0]
  output logic                      out_tuser    // overflow [0]
);
  import bc_pkg::*;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] n_r, n_nxt;
  logic [WORD_BITS-1:0] k_r, k_nxt;
  logic [WORD_BITS-1:0] d_r, d_nxt;
  logic [WORD_BITS-1:0] r_r, r_nxt;
  logic [WORD_BITS-1:0] mult_r, mult_nxt;
  logic                 divided_r, divided_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_coef_r, out_coef_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  alu_ctrl_t            alu_ctrl;
  alu_stat_t            alu_stat;
  logic [WORD_BITS-1:0] alu_a, alu_b;
  logic [WORD_BITS-1:0] alu_hi, alu_lo;

  logic                 out_free;
  logic                 in_xfer;

  assign out_free = !out_valid_r || out_tready;
  assign in_xfer  = in_tvalid && in_tready;

  bc_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (alu_ctrl),
    .opa   (alu_a),
    .opb   (alu_b),
    .stat  (alu_stat),
    .hi    (alu_hi),
    .lo    (alu_lo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_xfer) state_nxt = S_SETUP;
      S_SETUP:    state_nxt = (k_r > n_r) ? S_FIN : S_MINK;
      S_MINK:     state_nxt = S_LOOP;
      S_LOOP:     state_nxt = (d_r > k_r) ? S_FIN : S_WAIT_N;
      S_WAIT_N: begin
        if (alu_stat.done) state_nxt = (alu_hi == '0) ? S_MUL_GO : S_DIV_R_GO;
      end
      S_DIV_R_GO: state_nxt = S_WAIT_R;
      S_WAIT_R:   if (alu_stat.done) state_nxt = S_MUL_GO;
      S_MUL_GO:   state_nxt = S_WAIT_M;
      S_WAIT_M: begin
        if (alu_stat.done) begin
          priority if (alu_hi != '0) state_nxt = S_FIN;
          else if (divided_r)        state_nxt = S_STEP_END;
          else                       state_nxt = S_DIV_P_GO;
        end
      end
      S_DIV_P_GO: state_nxt = S_WAIT_P;
      S_WAIT_P:   if (alu_stat.done) state_nxt = S_STEP_END;
      S_STEP_END: state_nxt = S_LOOP;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: unit commands and datapath updates
  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    mult_nxt      = mult_r;
    divided_nxt   = divided_r;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_coef_nxt  = out_coef_r;
    out_ovf_nxt   = out_ovf_r;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_DIV;
    alu_a          = n_r;
    alu_b          = d_r;
    in_tready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          n_nxt = WORD_BITS'(in_tdata[DATA_W-1:0]);
          k_nxt = WORD_BITS'(in_tdata[2*DATA_W-1:DATA_W]);
        end
      end
      S_SETUP: begin
        res_nxt  = '0;
        ovf_nxt  = 1'b0;
        mult_nxt = n_r - k_r;
      end
      S_MINK: begin
        if (mult_r < k_r) k_nxt = mult_r;
        r_nxt = WORD_BITS'(1);
        d_nxt = WORD_BITS'(1);
      end
      S_LOOP: begin
        if (d_r > k_r) begin
          res_nxt = r_r;
          ovf_nxt = 1'b0;
        end else begin
          alu_ctrl.start = 1'b1;
        end
      end
      S_WAIT_N: begin
        if (alu_stat.done) begin
          if (alu_hi == '0) begin
            mult_nxt    = alu_lo;
            divided_nxt = 1'b1;
          end else begin
            mult_nxt = n_r;
          end
        end
      end
      S_DIV_R_GO: begin
        alu_ctrl.start = 1'b1;
        alu_a          = r_r;
      end
      S_WAIT_R: begin
        if (alu_stat.done) begin
          divided_nxt = (alu_hi == '0);
          if (alu_hi == '0) r_nxt = alu_lo;
        end
      end
      S_MUL_GO: begin
        alu_ctrl.start = 1'b1;
        alu_ctrl.op    = ALU_MUL;
        alu_a          = r_r;
        alu_b          = mult_r;
      end
      S_WAIT_M: begin
        if (alu_stat.done) begin
          if (alu_hi != '0) begin
            // product wrapped the word: report overflow and stop
            res_nxt = '0;
            ovf_nxt = 1'b1;
          end else begin
            r_nxt = alu_lo;
          end
        end
      end
      S_DIV_P_GO: begin
        alu_ctrl.start = 1'b1;
        alu_a          = r_r;
      end
      S_WAIT_P: begin
        if (alu_stat.done) r_nxt = alu_lo;
      end
      S_STEP_END: begin
        n_nxt       = n_r - 1'b1;
        d_nxt       = d_r + 1'b1;
        divided_nxt = 1'b0;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = DATA_W'(res_r);
          out_ovf_nxt   = ovf_r;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      divided_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      divided_r   <= divided_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    d_r        <= d_nxt;
    r_r        <= r_nxt;
    mult_r     <= mult_nxt;
    res_r      <= res_nxt;
    ovf_r      <= ovf_nxt;
    out_coef_r <= out_coef_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_coef_r;
  assign out_tuser  = out_ovf_r;

endmodule

@@ sim/binomial_coefficient_top_test.sv @@
// Self-checking bench for binomial_coefficient_top: streams (n, k) pairs and
// checks C(n,k) and the overflow flag against an in-bench model. Needs bc_pkg.
`timescale 1ns / 1ps

module binomial_coefficient_top_test;

  localparam int W = bc_pkg::DATA_W;

  typedef struct packed {
    logic [W-1:0] n_total;
    logic [W-1:0] k_chosen;
  } nk_pair_t;

  typedef struct packed {
    logic [W-1:0] coefficient;
    logic         overflow;
  } binom_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [2*W-1:0] in_tdata = '0;   // n_total [31:0], k_chosen [63:32]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [W-1:0] out_tdata;         // coefficient [31:0]
  logic         out_tuser;         // overflow [0]

  nk_pair_t      pending_pairs[$];
  binom_result_t expected_coeffs[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            mismatch_count = 0;

  binomial_coefficient_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Multiplicative C(n,k) on 32-bit words; any wrap of the product flags overflow.
  function automatic binom_result_t predict_binomial(logic [W-1:0] n_in, logic [W-1:0] k_in);
    logic [63:0]   word_max;
    logic [63:0]   n;
    logic [63:0]   k;
    logic [63:0]   prod;
    logic [63:0]   step;
    logic [63:0]   factor;
    bit            divided;
    bit            wrapped;
    binom_result_t res;
    word_max = 64'h0000_0000_FFFF_FFFF;
    n = {32'd0, n_in};
    k = {32'd0, k_in};
    prod = 64'd1;
    wrapped = 1'b0;
    if (k > n) begin
      res.coefficient = '0;
      res.overflow = 1'b0;
      return res;
    end
    if (n - k < k) begin
      k = n - k;
    end
    for (step = 64'd1; step <= k; step++) begin
      factor = n;
      divided = 1'b1;
      if (factor % step == 64'd0) begin
        factor = factor / step;
      end else if (prod % step == 64'd0) begin
        prod = prod / step;
      end else begin
        divided = 1'b0;
      end
      if (factor != 64'd0 && prod > word_max / factor) begin
        wrapped = 1'b1;
        break;
      end
      prod = (prod * factor) & word_max;
      if (!divided) begin
        prod = prod / step;
      end
      n = n - 64'd1;
    end
    res.coefficient = wrapped ? '0 : prod[W-1:0];
    res.overflow = wrapped;
    return res;
  endfunction

  // Driver: when the slot frees up, present the next pending pair unless a random idle is drawn.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_pairs[0].k_chosen, pending_pairs[0].n_total};
        pending_pairs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check on each output transfer.
  always @(posedge clk) begin
    binom_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_coeffs.size() == 0) begin
          $error("unexpected result: coefficient %0d overflow %0d", out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = expected_coeffs.pop_front();
          if (out_tdata !== want.coefficient) begin
            $error("coefficient: expected %0d, got %0d", want.coefficient, out_tdata);
            mismatch_count++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_coeffs.push_back(predict_binomial(in_tdata[W-1:0], in_tdata[2*W-1:W]));
      end
    end
  end

  task automatic queue_pair(logic [W-1:0] n, logic [W-1:0] k);
    nk_pair_t p;
    p.n_total = n;
    p.k_chosen = k;
    pending_pairs.push_back(p);
  endtask

  // Small n, huge n with k or n-k within 4, mid n with small k; some full-range noise for bit coverage.
  task automatic queue_random_pair();
    logic [W-1:0] n;
    logic [W-1:0] k;
    int           sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        n = $urandom_range(0, 67);
        k = $urandom_range(0, n + 2);
      end
      4, 5: begin
        n = $urandom();
        if ($urandom_range(0, 1) == 0 || n < 4) begin
          k = $urandom_range(0, 4);
        end else begin
          k = n - $urandom_range(0, 4);
        end
      end
      6: begin
        n = $urandom_range(68, 2000);
        k = $urandom_range(0, 20);
      end
      default: begin
        n = $urandom();
        k = $urandom();
      end
    endcase
    queue_pair(n, k);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_tvalid || expected_coeffs.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty and full choices, k above n, extremes, overflow edges.
    queue_pair(0, 0);
    queue_pair(0, 1);
    queue_pair(1, 0);
    queue_pair(1, 1);
    queue_pair(5, 2);
    queue_pair(10, 5);
    queue_pair(20, 10);
    queue_pair(33, 16);
    queue_pair(34, 17);
    queue_pair(67, 33);
    queue_pair(100, 3);
    queue_pair(65536, 2);
    queue_pair(92681, 2);
    queue_pair(32'h8000_0000, 1);
    queue_pair(32'hFFFF_FFFF, 0);
    queue_pair(32'hFFFF_FFFF, 1);
    queue_pair(32'hFFFF_FFFF, 2);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(0, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int i = 0; i < 125; i++) begin
        queue_random_pair();
      end
      // Sender holds off here until every result of the phase is back.
      drain();
    end

    repeat (4000) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** binomial_coefficient_top: PASSED **");
    end else begin
      $display("** binomial_coefficient_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("** binomial_coefficient_top: FAILED **");
    $finish;
  end

endmodule
